@@ design/histogram_matching_8bit_unit_defines.svh @@
// Assertion macros shared by the histogram matching unit
`ifndef HISTOGRAM_MATCHING_8BIT_UNIT_DEFINES_SVH
`define HISTOGRAM_MATCHING_8BIT_UNIT_DEFINES_SVH

// same-cycle implication
`define HM8_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HM8_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/hm8_pkg.sv @@
package hm8_pkg;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [7:0] mapped_pixel;
      logic       table_built;
   } rsp_type;

   localparam logic [2:0] OP_CLEAR    = 3'd0;
   localparam logic [2:0] OP_ADD_TGT  = 3'd1;
   localparam logic [2:0] OP_ADD_SRC  = 3'd2;
   localparam logic [2:0] OP_BUILD    = 3'd3;
   localparam logic [2:0] OP_MAP      = 3'd4;

   localparam logic [7:0] LEVEL_MAX   = 8'd255;

   typedef struct packed {
      logic latch_pix;
      logic clear;
      logic addr_pix;
      logic tsel;
      logic add_wr;
      logic bld_init;
      logic acc_t;
      logic acc_s;
      logic mul;
      logic lm_wr;
      logic inc_i;
      logic inc_v;
      logic load_map;
      logic load_build;
   } ctl_type;

   typedef struct packed {
      logic t_full;
      logic s_full;
      logic hit;
      logic v_last;
      logic rsp_busy;
   } sts_type;

endpackage

@@ design/hm8_ctrl.sv @@
module hm8_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [2:0]       req_op,
   output logic             req_stall,
   input  hm8_pkg::sts_type sts,
   output hm8_pkg::ctl_type ctl
);

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_ADD_RD  = 14'b00000000000010,
      ST_ADD_WR  = 14'b00000000000100,
      ST_MAP_RD  = 14'b00000000001000,
      ST_MAP_OUT = 14'b00000000010000,
      ST_BSTART  = 14'b00000000100000,
      ST_BRT0    = 14'b00000001000000,
      ST_BAT0    = 14'b00000010000000,
      ST_BRS     = 14'b00000100000000,
      ST_BAS     = 14'b00001000000000,
      ST_BRT     = 14'b00010000000000,
      ST_BAT     = 14'b00100000000000,
      ST_BMUL    = 14'b01000000000000,
      ST_BCMP    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      tsel_ff, tsel_in;
   logic      done_ff, done_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) || done_ff || sts.rsp_busy;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      tsel_in  = tsel_ff;
      done_in  = 1'b0;
      ctl      = '0;
      ctl.tsel = tsel_ff;
      ctl.load_build = done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.latch_pix = 1'b1;
               case (req_op)
                  hm8_pkg::OP_CLEAR: ctl.clear = 1'b1;
                  hm8_pkg::OP_ADD_TGT: begin
                     tsel_in = 1'b1;
                     if (!sts.t_full) state_in = ST_ADD_RD;
                  end
                  hm8_pkg::OP_ADD_SRC: begin
                     tsel_in = 1'b0;
                     if (!sts.s_full) state_in = ST_ADD_RD;
                  end
                  hm8_pkg::OP_BUILD: state_in = ST_BSTART;
                  hm8_pkg::OP_MAP:   state_in = ST_MAP_RD;
                  default: ;
               endcase
            end
         end
         ST_ADD_RD: begin
            ctl.addr_pix = 1'b1;
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            ctl.add_wr = 1'b1;
            state_in = ST_IDLE;
         end
         ST_MAP_RD:  state_in = ST_MAP_OUT;
         ST_MAP_OUT: begin
            ctl.load_map = 1'b1;
            state_in = ST_IDLE;
         end
         ST_BSTART: begin
            ctl.bld_init = 1'b1;
            state_in = ST_BRT0;
         end
         ST_BRT0: state_in = ST_BAT0;
         ST_BAT0: begin
            ctl.acc_t = 1'b1;
            state_in = ST_BRS;
         end
         ST_BRS: state_in = ST_BAS;
         ST_BAS: begin
            ctl.acc_s = 1'b1;
            state_in = ST_BMUL;
         end
         ST_BRT: state_in = ST_BAT;
         ST_BAT: begin
            ctl.acc_t = 1'b1;
            state_in = ST_BMUL;
         end
         ST_BMUL: begin
            ctl.mul = 1'b1;
            state_in = ST_BCMP;
         end
         ST_BCMP: begin
            if (sts.hit) begin
               ctl.lm_wr = 1'b1;
               if (sts.v_last) begin
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  ctl.inc_v = 1'b1;
                  state_in = ST_BRS;
               end
            end else begin
               ctl.inc_i = 1'b1;
               state_in = ST_BRT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      tsel_ff <= tsel_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

endmodule

@@ design/hm8_dpath.sv @@
module hm8_dpath #(
   parameter int MAX_PIXELS_LOG2 = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       req_pix,
   input  hm8_pkg::ctl_type ctl,
   output hm8_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hm8_pkg::rsp_type rsp_item
);

   localparam int W = MAX_PIXELS_LOG2 + 1;
   localparam logic [W-1:0] LIMIT = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};

   logic [W-1:0]   tc_mem [256];
   logic [W-1:0]   sc_mem [256];
   logic [7:0]     lm_mem [256];
   logic [255:0]   tv_ff, sv_ff;
   logic [7:0]     pix_ff, i_ff, v_ff, lmq_ff;
   logic [W-1:0]   ttot_ff, stot_ff, tq_ff, sq_ff, tcum_ff, scum_ff;
   logic           tvq_ff, svq_ff;
   logic [2*W-1:0] p1_ff, p2_ff;
   logic           rsp_valid_ff;
   hm8_pkg::rsp_type rsp_ff;
   logic [7:0]     taddr, saddr;
   logic [W-1:0]   tcnt, scnt;
   logic           t_zero;

   assign taddr  = ctl.addr_pix ? pix_ff : i_ff;
   assign saddr  = ctl.addr_pix ? pix_ff : v_ff;
   assign tcnt   = tvq_ff ? tq_ff : '0;
   assign scnt   = svq_ff ? sq_ff : '0;
   assign t_zero = (ttot_ff == '0);

   assign sts.t_full   = (ttot_ff >= LIMIT);
   assign sts.s_full   = (stot_ff >= LIMIT);
   assign sts.hit      = t_zero || (p1_ff >= p2_ff) || (i_ff == hm8_pkg::LEVEL_MAX);
   assign sts.v_last   = (v_ff == hm8_pkg::LEVEL_MAX);
   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      tq_ff  <= tc_mem[taddr];
      sq_ff  <= sc_mem[saddr];
      lmq_ff <= lm_mem[pix_ff];
      if (ctl.add_wr && ctl.tsel)  tc_mem[pix_ff] <= tcnt + W'(1);
      if (ctl.add_wr && !ctl.tsel) sc_mem[pix_ff] <= scnt + W'(1);
      if (ctl.lm_wr) lm_mem[v_ff] <= t_zero ? hm8_pkg::LEVEL_MAX : i_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.latch_pix) pix_ff <= req_pix;
      if (ctl.bld_init) begin
         i_ff    <= '0;
         v_ff    <= '0;
         tcum_ff <= '0;
         scum_ff <= '0;
      end else begin
         if (ctl.inc_i) i_ff <= i_ff + 8'd1;
         if (ctl.inc_v) v_ff <= v_ff + 8'd1;
         if (ctl.acc_t) tcum_ff <= tcum_ff + tcnt;
         if (ctl.acc_s) scum_ff <= scum_ff + scnt;
      end
      if (ctl.mul) begin
         p1_ff <= (2*W)'(tcum_ff) * (2*W)'(stot_ff);
         p2_ff <= (2*W)'(scum_ff) * (2*W)'(ttot_ff);
      end
      if (ctl.load_map) begin
         rsp_ff.mapped_pixel <= lmq_ff;
         rsp_ff.table_built  <= 1'b0;
      end else if (ctl.load_build) begin
         rsp_ff.mapped_pixel <= '0;
         rsp_ff.table_built  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff        <= '0;
         sv_ff        <= '0;
         ttot_ff      <= '0;
         stot_ff      <= '0;
         tvq_ff       <= 1'b0;
         svq_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tvq_ff <= tv_ff[taddr];
         svq_ff <= sv_ff[saddr];
         if (ctl.clear) begin
            tv_ff   <= '0;
            sv_ff   <= '0;
            ttot_ff <= '0;
            stot_ff <= '0;
         end else if (ctl.add_wr) begin
            if (ctl.tsel) begin
               tv_ff[pix_ff] <= 1'b1;
               ttot_ff       <= ttot_ff + W'(1);
            end else begin
               sv_ff[pix_ff] <= 1'b1;
               stot_ff       <= stot_ff + W'(1);
            end
         end
         if (ctl.load_map || ctl.load_build) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)                rsp_valid_ff <= 1'b0;
      end
   end

endmodule

@@ design/histogram_matching_8bit_unit.sv @@
// Clear: empties both histograms. Add target or source pixel: read, increment, write back;
// dropped when that histogram is full. Map: the level-map entry is read, then loaded as the result.
// Requests stall until the unit is idle and no result is stalled. Build: one merge walk over target
// and source levels on a shared multiply-compare; each step reads and adds a count, multiplies, compares.
// Synchronous reset empties both histograms at once by clearing per-level valid bits;
// the level map is undefined until the first build.
`include "histogram_matching_8bit_unit_defines.svh"

module histogram_matching_8bit_unit #(
   parameter int MAX_PIXELS_LOG2 = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hm8_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hm8_pkg::rsp_type rsp_item
);

   hm8_pkg::ctl_type ctl;
   hm8_pkg::sts_type sts;

   hm8_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_item.operation),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   hm8_dpath #(
      .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_pix   (req_item.pixel_value),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   `HM8_ASSERT_IMP(a_no_overwrite, clock, reset, ctl.load_map || ctl.load_build, !(rsp_valid && rsp_stall), "result item overwritten")
   `HM8_ASSERT_NXT(a_map_result, clock, reset, req_valid && !req_stall && req_item.operation == hm8_pkg::OP_MAP, ##2 rsp_valid, "map item gave no result")
   `HM8_ASSERT_IMP(a_build_zero, clock, reset, rsp_valid && rsp_item.table_built, rsp_item.mapped_pixel == 8'd0, "build result carries a level")

endmodule

@@ test/histogram_matching_8bit_unit_check.sv @@
module histogram_matching_8bit_unit_check #(
   parameter int MAX_PIXELS_LOG2 = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  hm8_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  hm8_pkg::rsp_type rsp_item,
   output int               failures,
   output int               pending
);

   localparam longint unsigned PIXEL_LIMIT = 64'd1 << MAX_PIXELS_LOG2;

   longint unsigned tgt_hist [256];
   longint unsigned src_hist [256];
   longint unsigned tgt_total;
   longint unsigned src_total;
   logic [7:0]      level_map [256];
   hm8_pkg::rsp_type expected_rsps [$];

   function automatic void build_level_map();
      longint unsigned tcum [256];
      longint unsigned acc;
      longint unsigned scum;
      longint unsigned rhs;
      logic [7:0]      pick;
      acc  = 0;
      scum = 0;
      for (int i = 0; i < 256; i++) begin
         acc     += tgt_hist[i];
         tcum[i] = acc;
      end
      for (int v = 0; v < 256; v++) begin
         pick = hm8_pkg::LEVEL_MAX;
         scum += src_hist[v];
         if (tgt_total != 0) begin
            rhs = scum * tgt_total;
            for (int i = 0; i < 256; i++) begin
               if (tcum[i] * src_total >= rhs) begin
                  pick = 8'(i);
                  break;
               end
            end
         end
         level_map[v] = pick;
      end
   endfunction

   function automatic void clear_hists();
      for (int i = 0; i < 256; i++) begin
         tgt_hist[i] = 0;
         src_hist[i] = 0;
      end
      tgt_total = 0;
      src_total = 0;
   endfunction

   function automatic void predict_item(hm8_pkg::req_type it);
      hm8_pkg::rsp_type r;
      case (it.operation)
         hm8_pkg::OP_CLEAR: clear_hists();
         hm8_pkg::OP_ADD_TGT: begin
            if (tgt_total < PIXEL_LIMIT) begin
               tgt_hist[it.pixel_value]++;
               tgt_total++;
            end
         end
         hm8_pkg::OP_ADD_SRC: begin
            if (src_total < PIXEL_LIMIT) begin
               src_hist[it.pixel_value]++;
               src_total++;
            end
         end
         hm8_pkg::OP_BUILD: begin
            build_level_map();
            r.mapped_pixel = '0;
            r.table_built  = 1'b1;
            expected_rsps.push_back(r);
         end
         hm8_pkg::OP_MAP: begin
            r.mapped_pixel = level_map[it.pixel_value];
            r.table_built  = 1'b0;
            expected_rsps.push_back(r);
         end
         default: ;
      endcase
   endfunction

   initial begin
      clear_hists();
      for (int i = 0; i < 256; i++) level_map[i] = '0;
   end

   always @(posedge clock) begin
      hm8_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) predict_item(req_item);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $time, rsp_item);
               failures++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_item.mapped_pixel !== want.mapped_pixel) begin
                  $display("%0t: mapped_pixel expected %0d actual %0d", $time,
                           want.mapped_pixel, rsp_item.mapped_pixel);
                  failures++;
               end
               if (rsp_item.table_built !== want.table_built) begin
                  $display("%0t: table_built expected %0b actual %0b", $time,
                           want.table_built, rsp_item.table_built);
                  failures++;
               end
            end
         end
      end
      pending = expected_rsps.size();
   end
endmodule

@@ test/histogram_matching_8bit_unit_test.sv @@
module histogram_matching_8bit_unit_test;

   localparam int  PIX_LOG2    = 8;
   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  ITEM_GOAL   = 1750;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   hm8_pkg::req_type req_item;
   logic             rsp_valid;
   logic             rsp_stall;
   hm8_pkg::rsp_type rsp_item;
   int      failures;
   int      pending;
   int      cycles;
   int      send_idle;
   int      recv_idle;
   int      sent;

   histogram_matching_8bit_unit #(.MAX_PIXELS_LOG2(PIX_LOG2)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   histogram_matching_8bit_unit_check #(.MAX_PIXELS_LOG2(PIX_LOG2)) u_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .failures(failures), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall = !reset && ($urandom_range(99) < recv_idle);
   end

   task automatic send_item(input logic [2:0] op, input logic [7:0] pix);
      logic stalled;
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid            = 1'b1;
      req_item.operation   = op;
      req_item.pixel_value = pix;
      do begin
         @(posedge clock);
         stalled = req_stall;
         @(negedge clock);
      end while (stalled);
      if (op <= hm8_pkg::OP_MAP) sent++;
   endtask

   task automatic pick_idling();
      if (sent < ITEM_GOAL / 3) begin
         send_idle = 37;
         recv_idle = 53;
      end else if (sent < 2 * ITEM_GOAL / 3) begin
         send_idle = 53;
         recv_idle = 37;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
   endtask

   initial begin
      int          len;
      int          roll;
      logic [2:0]  op;
      sent      = 0;
      send_idle = 37;
      recv_idle = 53;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: extremes, unused codes, empty target, empty source
      send_item(hm8_pkg::OP_ADD_TGT, 8'd0);
      send_item(hm8_pkg::OP_ADD_TGT, 8'd255);
      send_item(hm8_pkg::OP_ADD_SRC, 8'd0);
      send_item(hm8_pkg::OP_ADD_SRC, 8'd255);
      send_item(hm8_pkg::OP_ADD_SRC, 8'd170);
      send_item(hm8_pkg::OP_BUILD, 8'd85);
      send_item(hm8_pkg::OP_MAP, 8'd0);
      send_item(hm8_pkg::OP_MAP, 8'd255);
      send_item(hm8_pkg::OP_MAP, 8'd170);
      send_item(3'd5, 8'd1);
      send_item(3'd6, 8'd2);
      send_item(3'd7, 8'd3);
      send_item(hm8_pkg::OP_CLEAR, 8'd255);
      send_item(hm8_pkg::OP_ADD_SRC, 8'd42);
      send_item(hm8_pkg::OP_BUILD, 8'd0);
      send_item(hm8_pkg::OP_MAP, 8'd42);
      send_item(hm8_pkg::OP_CLEAR, 8'd0);
      send_item(hm8_pkg::OP_ADD_TGT, 8'd100);
      send_item(hm8_pkg::OP_BUILD, 8'd0);
      send_item(hm8_pkg::OP_MAP, 8'd7);
      send_item(hm8_pkg::OP_CLEAR, 8'd0);
      send_item(hm8_pkg::OP_BUILD, 8'd0);
      send_item(hm8_pkg::OP_MAP, 8'd128);

      // random: clear, a run of mostly adds and maps (with some builds and unused codes), build, then some maps
      while (sent < ITEM_GOAL) begin
         pick_idling();
         send_item(hm8_pkg::OP_CLEAR, 8'($urandom));
         len = ($urandom_range(3) == 0) ? $urandom_range(300, 650) : $urandom_range(5, 150);
         for (int k = 0; k < len; k++) begin
            pick_idling();
            roll = $urandom_range(99);
            if (roll < 45)      op = hm8_pkg::OP_ADD_TGT;
            else if (roll < 80) op = hm8_pkg::OP_ADD_SRC;
            else if (roll < 95) op = hm8_pkg::OP_MAP;
            else if (roll < 97) op = hm8_pkg::OP_BUILD;
            else                op = 3'($urandom_range(5, 7));
            send_item(op, ($urandom_range(3) == 0) ? 8'($urandom_range(120, 135))
                                                   : 8'($urandom));
         end
         send_item(hm8_pkg::OP_BUILD, 8'($urandom));
         repeat ($urandom_range(20)) send_item(hm8_pkg::OP_MAP, 8'($urandom));
      end

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
